// ----- rtl/kpf_pkg.sv -----
// ----------------------------------------------------------------------------
// kpf_pkg: shared types and constants of the Kasiski period finder
// Payload structs, configuration register indexes and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package kpf_pkg;

  localparam int MAX_TEXT  = 4096;
  localparam int MAX_NGRAM = 8;
  localparam int FIELD_MAX = 4095;

  localparam int CFG_DW  = 8;
  localparam int CFG_IW  = 1;
  localparam int FIELD_W = 12;

  localparam logic [CFG_IW-1:0] CFG_NGRAM_LEN  = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_SKIP_COUNT = 1'd1;

  localparam logic [3:0] NGRAM_LEN_RESET  = 4'd3;
  localparam logic [7:0] SKIP_COUNT_RESET = 8'd0;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic               repeat_found;
    logic [FIELD_W-1:0] period_gcd;
    logic [FIELD_W-1:0] distance_count;
    logic               text_overflow;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic init;
    logic drop_skip;
    logic k_inc;
    logic skip_take;
    logic keep;
    logic gcd_step;
    logic next_off;
    logic next_start;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic too_short;
    logic skip_next;
    logic byte_eq;
    logic last_k;
    logic skips_nz;
    logic gcd_done;
    logic last_off;
    logic last_start;
    logic found;
  } status_t;

endpackage

// ----- rtl/kpf_datapath.sv -----
// ----------------------------------------------------------------------------
// kpf_datapath: text store, search counters and GCD unit
// Holds the ciphertext memory, the start/offset/byte counters, the skip
// bookkeeping and a subtractive GCD pair, all driven by controller commands.
// ----------------------------------------------------------------------------
module kpf_datapath #(
  parameter int MaxText  = kpf_pkg::MAX_TEXT,
  parameter int MaxNgram = kpf_pkg::MAX_NGRAM
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [kpf_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [kpf_pkg::CFG_DW-1:0] cfg_data_i,
  input  kpf_pkg::in_item_t          in_i,
  input  kpf_pkg::cmd_t              cmd_i,
  output kpf_pkg::status_t           status_o,
  output kpf_pkg::out_item_t         result_o
);

  localparam int AW = $clog2(MaxText);
  localparam int LW = $clog2(MaxText + 1);
  localparam int NW = $clog2(MaxNgram + 1);
  localparam int FW = kpf_pkg::FIELD_W;

  logic [7:0]    mem [MaxText];
  logic [7:0]    rd_a_q, rd_b_q;

  logic [3:0]    ngram_q;
  logic [7:0]    skip_cfg_q;
  logic [LW-1:0] len_q;
  logic          ovf_q;
  logic [NW-1:0] n_q;
  logic [AW-1:0] i_q, q_q, prev_q;
  logic [NW-1:0] k_q;
  logic [7:0]    skips_q;
  logic          skip_next_q;
  logic          found_q;
  logic [FW-1:0] count_q;
  logic [AW-1:0] gcd_a_q, gcd_b_q;

  logic          full;
  logic [NW-1:0] n_eff;
  logic [LW-1:0] lim;
  logic [AW-1:0] addr_a, addr_b;
  logic [FW-1:0] gcd_sat;

  assign full   = (len_q == LW'(MaxText));
  assign lim    = len_q - LW'(n_q);
  assign addr_a = i_q + AW'(k_q);
  assign addr_b = q_q + AW'(k_q);

  always_comb begin
    if (ngram_q == 4'd0) begin
      n_eff = NW'(1);
    end else if (32'(ngram_q) > 32'(MaxNgram)) begin
      n_eff = NW'(MaxNgram);
    end else begin
      n_eff = NW'(ngram_q);
    end
  end

  // Text store: one write port for loading, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem[len_q[AW-1:0]] <= in_i.text_byte;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ngram_q     <= kpf_pkg::NGRAM_LEN_RESET;
      skip_cfg_q  <= kpf_pkg::SKIP_COUNT_RESET;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      n_q         <= NW'(1);
      i_q         <= '0;
      q_q         <= '0;
      prev_q      <= '0;
      k_q         <= '0;
      skips_q     <= '0;
      skip_next_q <= 1'b0;
      found_q     <= 1'b0;
      count_q     <= '0;
      gcd_a_q     <= '0;
      gcd_b_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kpf_pkg::CFG_NGRAM_LEN:  ngram_q    <= cfg_data_i[3:0];
          kpf_pkg::CFG_SKIP_COUNT: skip_cfg_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          len_q <= len_q + LW'(1);
        end
      end
      if (cmd_i.init) begin
        n_q         <= n_eff;
        i_q         <= '0;
        q_q         <= AW'(1);
        prev_q      <= '0;
        k_q         <= '0;
        skips_q     <= skip_cfg_q;
        skip_next_q <= 1'b0;
        found_q     <= 1'b0;
        count_q     <= '0;
        gcd_a_q     <= '0;
        gcd_b_q     <= '0;
      end
      if (cmd_i.drop_skip) begin
        skip_next_q <= 1'b0;
      end
      if (cmd_i.k_inc) begin
        k_q <= k_q + NW'(1);
      end
      if (cmd_i.skip_take) begin
        skips_q     <= skips_q - 8'd1;
        skip_next_q <= 1'b1;
      end
      if (cmd_i.keep) begin
        found_q <= 1'b1;
        gcd_b_q <= q_q - prev_q;
        prev_q  <= q_q;
        if (count_q != FW'(kpf_pkg::FIELD_MAX)) begin
          count_q <= count_q + FW'(1);
        end
      end
      if (cmd_i.gcd_step) begin
        if (gcd_a_q < gcd_b_q) begin
          gcd_a_q <= gcd_b_q;
          gcd_b_q <= gcd_a_q;
        end else begin
          gcd_a_q <= gcd_a_q - gcd_b_q;
        end
      end
      if (cmd_i.next_off) begin
        q_q <= q_q + AW'(1);
        k_q <= '0;
      end
      if (cmd_i.next_start) begin
        i_q    <= i_q + AW'(1);
        q_q    <= i_q + AW'(2);
        prev_q <= i_q + AW'(1);
        k_q    <= '0;
      end
      if (cmd_i.clear) begin
        len_q <= '0;
        ovf_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o.too_short  = (len_q <= LW'(n_q));
    status_o.skip_next  = skip_next_q;
    status_o.byte_eq    = (rd_a_q == rd_b_q);
    status_o.last_k     = (k_q == n_q - NW'(1));
    status_o.skips_nz   = (skips_q != 8'd0);
    status_o.gcd_done   = (gcd_b_q == '0);
    status_o.last_off   = (LW'(q_q) == lim);
    status_o.last_start = ({1'b0, i_q} + (AW + 1)'(1) >= (AW + 1)'(lim));
    status_o.found      = found_q;
  end

  always_comb begin
    if (32'(gcd_a_q) > 32'(kpf_pkg::FIELD_MAX)) begin
      gcd_sat = FW'(kpf_pkg::FIELD_MAX);
    end else begin
      gcd_sat = FW'(gcd_a_q);
    end
    result_o.repeat_found   = found_q;
    result_o.period_gcd     = found_q ? gcd_sat : '0;
    result_o.distance_count = count_q;
    result_o.text_overflow  = ovf_q;
  end

endmodule

// ----- rtl/kpf_ctrl.sv -----
// ----------------------------------------------------------------------------
// kpf_ctrl: search sequencer of the Kasiski period finder
// Accepts bytes while idle, then steps the datapath through start
// positions, offsets, byte compares and GCD iterations.
// ----------------------------------------------------------------------------
module kpf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             last_i,
  input  kpf_pkg::status_t status_i,
  output kpf_pkg::cmd_t    cmd_o,
  output logic             busy_o,
  output logic             done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_START,
    S_OFFSET,
    S_CMP,
    S_GCD,
    S_ADV,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (last_i) begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_START;
      end
      S_START: begin
        state_d = status_i.too_short ? S_DONE : S_OFFSET;
      end
      S_OFFSET: begin
        // the read of the current byte pair is in flight here
        if (status_i.skip_next) begin
          cmd_o.drop_skip = 1'b1;
          state_d         = S_ADV;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (!status_i.byte_eq) begin
          state_d = S_ADV;
        end else if (!status_i.last_k) begin
          cmd_o.k_inc = 1'b1;
          state_d     = S_OFFSET;
        end else if (status_i.skips_nz) begin
          cmd_o.skip_take = 1'b1;
          state_d         = S_ADV;
        end else begin
          cmd_o.keep = 1'b1;
          state_d    = S_GCD;
        end
      end
      S_GCD: begin
        if (status_i.gcd_done) begin
          state_d = S_ADV;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_ADV: begin
        if (!status_i.last_off) begin
          cmd_o.next_off = 1'b1;
          state_d        = S_OFFSET;
        end else if (status_i.found || status_i.last_start) begin
          state_d = S_DONE;
        end else begin
          cmd_o.next_start = 1'b1;
          state_d          = S_OFFSET;
        end
      end
      S_DONE: begin
        cmd_o.clear = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
      done_q  <= (state_d == S_DONE);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// ----- rtl/kasiski_period_finder_top.sv -----
// ----------------------------------------------------------------------------
// kasiski_period_finder_top: Kasiski examination of a stored ciphertext
// Loads ciphertext bytes, searches for repeated n-grams and reports the GCD
// of the distances between kept repeats.
// ----------------------------------------------------------------------------
// Usage:
//   Input transaction: text byte plus last flag, taken at a clock edge with
//   start_i high and busy_o low. While loading, busy_o stays low, so one byte
//   enters per cycle. Bytes past MaxText are dropped and flagged.
//   The byte marked last launches the search; busy_o rises on the next cycle
//   and stays high until the result transaction has gone out.
//   Result transaction: result_o is valid for the single cycle done_o is high.
//   There is no back-pressure; the receiver must take it in that cycle.
//   Search steps: each byte pair is read in an offset state and compared in
//   a compare state; each offset ends in an advance state (a skipped offset
//   goes there straight from its offset state); each kept match runs the
//   subtractive GCD unit, one subtraction or swap per step, until the second
//   operand is zero. Setup and wrap-up are init, length check and result.
//   One byte pair is compared at a time over the two-read text store.
//   Configuration: cfg_we_i writes ngram_len (index 0) or skip_count
//   (index 1); write only while busy_o is low and no text is being loaded.
//   Reset: clears the text length, overflow flag and search state and puts
//   ngram_len at 3, skip_count at 0. The store itself needs no clearing.
// ----------------------------------------------------------------------------
module kasiski_period_finder_top #(
  parameter int MaxText  = kpf_pkg::MAX_TEXT,
  parameter int MaxNgram = kpf_pkg::MAX_NGRAM
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  kpf_pkg::in_item_t          in_i,
  output logic                       done_o,
  output kpf_pkg::out_item_t         result_o,
  input  logic                       cfg_we_i,
  input  logic [kpf_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [kpf_pkg::CFG_DW-1:0] cfg_data_i
);

  kpf_pkg::cmd_t    cmd;
  kpf_pkg::status_t status;

  // Sequencer: owns the handshake and walks the search loops.
  kpf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .last_i   (in_i.last_byte),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  // Datapath: store, counters, skip logic and GCD pair.
  kpf_datapath #(
    .MaxText  (MaxText),
    .MaxNgram (MaxNgram)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .result_o   (result_o)
  );

  // A result goes out only from inside a search.
  a_done_in_search : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe outside a search");

  // Exactly one strobe per search, then back to idle.
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy_o))
    else $error("result strobe not followed by idle");

  // The last byte always launches a search.
  a_last_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && in_i.last_byte) |=> busy_o)
    else $error("last byte did not start a search");

  // A found repeat carries at least one kept distance and a nonzero GCD.
  a_found_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.repeat_found) |->
      (result_o.distance_count != '0 && result_o.period_gcd != '0))
    else $error("found flag without kept distance");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the Kasiski period finder
// Streams ciphertext texts through the input port, rebuilds each search in
// a local scan of the stored text and compares every result transaction
// field by field. Covers the reset settings, n-gram length and skip
// extremes, and keyed, small-alphabet and noise texts, with random sender
// gaps.
// ----------------------------------------------------------------------------
module testbench;

  // Cycles with no transaction before the run is declared hung.
  // The longest text the bench can send is 48 bytes.
  localparam int unsigned STALL_LIMIT = 200000;
  // Cycles to hold off after the last result before touching registers.
  localparam int unsigned HOLD_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES = 20;

  typedef enum int unsigned {
    TEXT_KEYED,
    TEXT_SMALL_ALPHA,
    TEXT_NOISE
  } text_style_e;

  logic                       clk_i      = 1'b0;
  logic                       rst_ni     = 1'b0;
  logic                       start_i    = 1'b0;
  logic                       busy_o;
  kpf_pkg::in_item_t          in_i       = '0;
  logic                       done_o;
  kpf_pkg::out_item_t         result_o;
  logic                       cfg_we_i   = 1'b0;
  logic [kpf_pkg::CFG_IW-1:0] cfg_idx_i  = kpf_pkg::CFG_NGRAM_LEN;
  logic [kpf_pkg::CFG_DW-1:0] cfg_data_i = '0;

  // Local copy of the block's state and registers.
  logic [7:0]  text_mem [kpf_pkg::MAX_TEXT];
  int unsigned text_len  = 0;
  bit          text_ovf  = 1'b0;
  logic [3:0]  ngram_cfg = kpf_pkg::NGRAM_LEN_RESET;
  logic [7:0]  skip_cfg  = kpf_pkg::SKIP_COUNT_RESET;

  kpf_pkg::out_item_t pending_results[$];
  logic [7:0]         text_buf[$];
  bit                 sender_idles = 1'b0;

  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned bytes_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned repeats_seen   = 0;
  int unsigned overflows_seen = 0;
  int unsigned settings_used  = 0;

  kasiski_period_finder_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Rebuild the search over the text held so far: walk start positions,
  // compare each n-gram with every later one, burn the skip budget (each
  // discard also drops the next offset) and fold kept distances into a GCD.
  function automatic kpf_pkg::out_item_t kasiski_scan();
    kpf_pkg::out_item_t res;
    int unsigned        n, i, j, k, prev, skips, g, a, b, t, kept;
    bit                 skip_nx, found, same;
    n = ngram_cfg;
    if (n == 0) n = 1;
    if (n > kpf_pkg::MAX_NGRAM) n = kpf_pkg::MAX_NGRAM;
    skips   = skip_cfg;
    skip_nx = 1'b0;
    found   = 1'b0;
    g       = 0;
    kept    = 0;
    if (text_len > n) begin
      for (i = 0; (i + n < text_len) && !found; i++) begin
        prev = i;
        for (j = 1; j <= text_len - n - i; j++) begin
          if (skip_nx) begin
            skip_nx = 1'b0;
            continue;
          end
          same = 1'b1;
          for (k = 0; k < n; k++) begin
            if (text_mem[i+k] != text_mem[i+j+k]) same = 1'b0;
          end
          if (!same) continue;
          if (skips != 0) begin
            skips--;
            skip_nx = 1'b1;
            continue;
          end
          found = 1'b1;
          a = g;
          b = i + j - prev;
          while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
          end
          g    = a;
          prev = i + j;
          if (kept < kpf_pkg::FIELD_MAX) kept++;
        end
      end
    end
    if (!found) g = 0;
    if (g > kpf_pkg::FIELD_MAX) g = kpf_pkg::FIELD_MAX;
    res.repeat_found   = found;
    res.period_gcd     = kpf_pkg::FIELD_W'(g);
    res.distance_count = kpf_pkg::FIELD_W'(kept);
    res.text_overflow  = text_ovf;
    return res;
  endfunction

  // Observe every transaction at the clock edge: register writes, accepted
  // bytes and result strobes. Also run the stall watchdog here.
  always @(posedge clk_i) begin
    kpf_pkg::out_item_t want;
    if (rst_ni) begin
      quiet_cycles++;
      if (cfg_we_i) begin
        quiet_cycles = 0;
        if (cfg_idx_i == kpf_pkg::CFG_NGRAM_LEN) begin
          ngram_cfg = cfg_data_i[3:0];
        end else if (cfg_idx_i == kpf_pkg::CFG_SKIP_COUNT) begin
          skip_cfg = cfg_data_i;
        end
      end
      if (start_i && !busy_o) begin
        quiet_cycles = 0;
        bytes_sent++;
        // Store the byte, or drop it once the store is full.
        if (text_len < kpf_pkg::MAX_TEXT) begin
          text_mem[text_len] = in_i.text_byte;
          text_len++;
        end else begin
          text_ovf = 1'b1;
        end
        if (in_i.last_byte) begin
          pending_results.push_back(kasiski_scan());
          text_len = 0;
          text_ovf = 1'b0;
        end
      end
      if (done_o) begin
        quiet_cycles = 0;
        results_seen++;
        if (pending_results.size() == 0) begin
          flag_mismatch("result with no text pending", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (result_o.repeat_found) repeats_seen++;
          if (result_o.text_overflow) overflows_seen++;
          if (result_o.repeat_found !== want.repeat_found)
            flag_mismatch("repeat_found", result_o.repeat_found, want.repeat_found);
          if (result_o.period_gcd !== want.period_gcd)
            flag_mismatch("period_gcd", result_o.period_gcd, want.period_gcd);
          if (result_o.distance_count !== want.distance_count)
            flag_mismatch("distance_count", result_o.distance_count,
                          want.distance_count);
          if (result_o.text_overflow !== want.text_overflow)
            flag_mismatch("text_overflow", result_o.text_overflow,
                          want.text_overflow);
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Send one byte; optionally idle first. Leave start high on return so the
  // next byte can follow in the very next cycle.
  task automatic send_byte(input logic [7:0] value, input logic last);
    kpf_pkg::in_item_t item;
    item.text_byte = value;
    item.last_byte = last;
    if (sender_idles && ($urandom_range(0, 3) == 0)) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= item;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Send text_buf as one text, last flag on its final byte.
  task automatic send_text();
    int unsigned k;
    for (k = 0; k < text_buf.size(); k++) begin
      send_byte(text_buf[k], k == text_buf.size() - 1);
    end
  endtask

  // Drop start and hold until every pending result has come, then let the
  // block settle.
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (HOLD_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers back to back; only called while the block is idle.
  // Upper data bits of the n-gram write are junk the block must ignore.
  task automatic set_config(input logic [3:0] ngram, input logic [7:0] skip);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= kpf_pkg::CFG_NGRAM_LEN;
    cfg_data_i <= {4'($urandom), ngram};
    @(posedge clk_i);
    cfg_idx_i  <= kpf_pkg::CFG_SKIP_COUNT;
    cfg_data_i <= skip;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_used++;
  endtask

  task automatic load_text(input logic [7:0] b0, input logic [7:0] b1,
                           input int unsigned len);
    int unsigned k;
    text_buf.delete();
    for (k = 0; k < len; k++) text_buf.push_back((k % 2 == 0) ? b0 : b1);
  endtask

  // Fill text_buf with a random text: mostly a repeating key with some
  // corruption, else a small alphabet, else pure noise.
  task automatic build_random_text(input int unsigned len);
    text_style_e style;
    int unsigned period, k, pick;
    logic [7:0]  key   [8];
    logic [7:0]  alpha [3];
    pick   = $urandom_range(0, 9);
    style  = (pick < 6) ? TEXT_KEYED : (pick < 8) ? TEXT_SMALL_ALPHA : TEXT_NOISE;
    period = $urandom_range(1, 8);
    for (k = 0; k < 8; k++) key[k] = 8'($urandom);
    for (k = 0; k < 3; k++) alpha[k] = 8'($urandom);
    text_buf.delete();
    for (k = 0; k < len; k++) begin
      case (style)
        TEXT_KEYED: begin
          text_buf.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                         : key[k % period]);
        end
        TEXT_SMALL_ALPHA: begin
          text_buf.push_back(alpha[$urandom_range(0, 2)]);
        end
        default: begin
          text_buf.push_back(8'($urandom));
        end
      endcase
    end
  endtask

  function automatic int unsigned random_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(33, 48)
                                       : $urandom_range(1, 32);
  endfunction

  // Reset settings (n-gram 3, no skips): one-byte text, text no longer than
  // the n-gram, and a short text with one repeat.
  task automatic test_reset_settings();
    text_buf = '{8'h00};
    send_text();
    text_buf = '{8'hFF, 8'hFF, 8'hFF};
    send_text();
    text_buf = '{8'h41, 8'h42, 8'h43, 8'h41, 8'h42, 8'h43, 8'h41};
    send_text();
    drain();
  endtask

  // N-gram length at and beyond its limits: zero acts as one, above the
  // maximum acts as the maximum.
  task automatic test_ngram_limits();
    set_config(4'd0, 8'd0);
    text_buf = '{8'h05, 8'h05};
    send_text();
    drain();
    set_config(4'd15, 8'd0);
    load_text(8'hAA, 8'hAA, 9);
    send_text();
    drain();
    set_config(4'd8, 8'd0);
    load_text(8'h80, 8'h7F, 12);
    send_text();
    drain();
    set_config(4'd1, 8'd0);
    load_text(8'h01, 8'hFE, 6);
    send_text();
    drain();
  endtask

  // Skip budget: one discard (which also drops the next offset), and the
  // full budget that swallows every match of a short text.
  task automatic test_skip_budget();
    set_config(4'd1, 8'd1);
    load_text(8'h41, 8'h42, 8);
    send_text();
    drain();
    set_config(4'd2, 8'd255);
    load_text(8'h10, 8'h20, 10);
    send_text();
    drain();
  endtask

  // Random texts over a run of settings, extremes first, with random sender
  // gaps in most phases and none in some.
  task automatic test_random_texts();
    int unsigned phase, k, phase_texts, sent;
    logic [3:0]  ngram;
    logic [7:0]  skip;
    phase = 0;
    sent  = 0;
    while (sent < 650) begin
      case (phase)
        0: begin ngram = 4'd1;  skip = 8'd0;   end
        1: begin ngram = 4'd8;  skip = 8'd255; end
        2: begin ngram = 4'd0;  skip = 8'd1;   end
        3: begin ngram = 4'd15; skip = 8'd0;   end
        default: begin
          ngram = 4'($urandom_range(0, 15));
          k     = $urandom_range(0, 9);
          skip  = (k < 5) ? 8'($urandom_range(0, 3)) :
                  (k < 8) ? 8'($urandom) : 8'd255;
        end
      endcase
      set_config(ngram, skip);
      sender_idles = ($urandom_range(0, 3) != 0);
      phase_texts  = $urandom_range(3, 6);
      for (k = 0; k < phase_texts; k++) begin
        build_random_text(random_length());
        sent += text_buf.size();
        send_text();
      end
      drain();
      phase++;
    end
  endtask

  // Closing stretch: texts back to back with no sender gaps, held once
  // midway until every result is in.
  task automatic test_back_to_back();
    int unsigned k;
    sender_idles = 1'b0;
    set_config(4'($urandom_range(1, 4)), 8'($urandom_range(0, 2)));
    for (k = 0; k < 10; k++) begin
      if (k == 5) begin
        start_i <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      build_random_text(random_length());
      send_text();
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_settings();
    test_ngram_limits();
    test_skip_budget();
    test_random_texts();
    test_back_to_back();

    // Hold until nothing is outstanding, then give the block a tail.
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      flag_mismatch("results never produced", 0, pending_results.size());

    $display("coverage: %0d bytes in, %0d results checked under %0d settings",
             bytes_sent, results_seen, settings_used);
    $display("coverage: %0d texts with a kept repeat, %0d with dropped bytes",
             repeats_seen, overflows_seen);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
